[rtl/core/dmx512_slot_receiver_unit_defines.svh]
// ----------------------------------------------------------------------------
// dmx512_slot_receiver_unit_defines
// assertion macros shared by the slot receiver modules
// ----------------------------------------------------------------------------
`ifndef DMX512_SLOT_RECEIVER_UNIT_DEFINES_SVH
`define DMX512_SLOT_RECEIVER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define DMXSR_ASSERT_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
`define DMXSR_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define DMXSR_ASSERT_NOW(lbl, ante, cons, msg)
`define DMXSR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/core/dmxsr_pkg.sv]
// ----------------------------------------------------------------------------
// dmxsr_pkg
// shared constants and types of the dmx512 slot receiver
// ----------------------------------------------------------------------------
`default_nettype none

package dmxsr_pkg;

   localparam int TIMER_W     = 20;
   localparam int FRAME_SLOTS = 513;
   localparam int SLOT_NUM_W  = 10;
   localparam int BYTE_W      = 8;
   localparam int BIT_TICKS_W = 8;
   localparam int BIT_POS_W   = 4;
   localparam int FAULT_W     = 10;

   localparam logic [BIT_POS_W-1:0] START_BIT = 4'd0;
   localparam logic [BIT_POS_W-1:0] LAST_DATA_BIT = 4'd8;
   localparam logic [BIT_POS_W-1:0] LAST_BIT  = 4'd10;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_MIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BREAK_MIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_TICKS = 2'd2;

   localparam logic [TIMER_W-1:0]     IDLE_MIN_RST  = 20'd1000;
   localparam logic [TIMER_W-1:0]     BREAK_MIN_RST = 20'd1000;
   localparam logic [BIT_TICKS_W-1:0] BIT_TICKS_RST = 8'd4;
   localparam logic [BIT_TICKS_W-1:0] BIT_TICKS_MIN = 8'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   // one mid-bit sample handed from the framing front to the slot assembler
   typedef struct packed {
      logic [BIT_POS_W-1:0]  bit_pos;
      logic                  level;
      logic [SLOT_NUM_W-1:0] slot_num;
      logic                  last;
   } event_type;

endpackage

`default_nettype wire

[rtl/core/dmxsr_front.sv]
// ----------------------------------------------------------------------------
// dmxsr_front
// line sample intake: idle, break and slot framing, mid-bit sample events
// ----------------------------------------------------------------------------
`default_nettype none
`include "dmx512_slot_receiver_unit_defines.svh"

module dmxsr_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_line_level,
   input  logic                               csr_wr_en,
   input  logic [dmxsr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dmxsr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                               queue_full,
   output logic                               ev_push,
   output dmxsr_pkg::event_type               ev_out
);
   import dmxsr_pkg::*;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_BREAK = 2'd1;
   localparam logic [1:0] PH_WAIT  = 2'd2;
   localparam logic [1:0] PH_BITS  = 2'd3;

   logic [TIMER_W-1:0]     idle_min_ff;
   logic [TIMER_W-1:0]     break_min_ff;
   logic [BIT_TICKS_W-1:0] bit_ticks_ff;

   logic [1:0]            phase_ff, phase_in;
   logic [TIMER_W-1:0]    elapsed_ff, elapsed_in;
   logic [BIT_POS_W-1:0]  bit_pos_ff, bit_pos_in;
   logic [SLOT_NUM_W-1:0] slot_cnt_ff, slot_cnt_in;

   logic                   accept;
   logic [BIT_TICKS_W-1:0] bt;
   logic [BIT_TICKS_W-1:0] half;
   logic [BIT_TICKS_W:0]   tick_sum;
   logic                   wrap;
   logic [BIT_TICKS_W-1:0] tick_next;
   logic [BIT_POS_W-1:0]   pos_next;
   logic                   sample_hit;
   logic                   last_slot;
   logic [TIMER_W-1:0]     elapsed_inc;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   assign bt        = (bit_ticks_ff < BIT_TICKS_MIN) ? BIT_TICKS_MIN : bit_ticks_ff;
   assign half      = {1'b0, bt[BIT_TICKS_W-1:1]};
   assign tick_sum  = {1'b0, elapsed_ff[BIT_TICKS_W-1:0]} + {{BIT_TICKS_W{1'b0}}, 1'b1};
   assign wrap      = tick_sum >= {1'b0, bt};
   assign tick_next = wrap ? '0 : tick_sum[BIT_TICKS_W-1:0];
   assign pos_next  = wrap ? bit_pos_ff + {{(BIT_POS_W-1){1'b0}}, 1'b1} : bit_pos_ff;
   assign sample_hit = tick_next == half;
   assign last_slot  = slot_cnt_ff >= SLOT_NUM_W'(FRAME_SLOTS - 1);
   assign elapsed_inc = (&elapsed_ff) ? elapsed_ff
                                      : elapsed_ff + {{(TIMER_W-1){1'b0}}, 1'b1};

   assign ev_out.bit_pos  = pos_next;
   assign ev_out.level    = req_line_level;
   assign ev_out.slot_num = slot_cnt_ff;
   assign ev_out.last     = last_slot;

   always_comb begin
      phase_in    = phase_ff;
      elapsed_in  = elapsed_ff;
      bit_pos_in  = bit_pos_ff;
      slot_cnt_in = slot_cnt_ff;
      ev_push     = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_IDLE: begin
               if (req_line_level) begin
                  elapsed_in = elapsed_inc;
               end else if (elapsed_ff > idle_min_ff) begin
                  phase_in   = PH_BREAK;
                  elapsed_in = TIMER_W'(1);
               end else begin
                  elapsed_in = '0;
               end
            end
            PH_BREAK: begin
               if (!req_line_level) begin
                  elapsed_in = elapsed_inc;
               end else if (elapsed_ff > break_min_ff) begin
                  phase_in    = PH_WAIT;
                  elapsed_in  = '0;
                  slot_cnt_in = '0;
               end else begin
                  phase_in   = PH_IDLE;
                  elapsed_in = TIMER_W'(1);
               end
            end
            PH_WAIT: begin
               if (!req_line_level) begin
                  phase_in   = PH_BITS;
                  elapsed_in = '0;
                  bit_pos_in = START_BIT;
               end
            end
            PH_BITS: begin
               elapsed_in = TIMER_W'(tick_next);
               bit_pos_in = pos_next;
               if (sample_hit) begin
                  ev_push = 1'b1;
                  if (pos_next >= LAST_BIT) begin
                     slot_cnt_in = slot_cnt_ff + {{(SLOT_NUM_W-1){1'b0}}, 1'b1};
                     bit_pos_in  = START_BIT;
                     elapsed_in  = '0;
                     phase_in    = last_slot ? PH_IDLE : PH_WAIT;
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         elapsed_ff   <= '0;
         bit_pos_ff   <= '0;
         slot_cnt_ff  <= '0;
         idle_min_ff  <= IDLE_MIN_RST;
         break_min_ff <= BREAK_MIN_RST;
         bit_ticks_ff <= BIT_TICKS_RST;
      end else begin
         phase_ff    <= phase_in;
         elapsed_ff  <= elapsed_in;
         bit_pos_ff  <= bit_pos_in;
         slot_cnt_ff <= slot_cnt_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_IDLE_MIN:  idle_min_ff  <= csr_wdata[TIMER_W-1:0];
               CSR_BREAK_MIN: break_min_ff <= csr_wdata[TIMER_W-1:0];
               CSR_BIT_TICKS: bit_ticks_ff <= csr_wdata[BIT_TICKS_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   `DMXSR_ASSERT_NOW(a_push_in_bits, ev_push, phase_ff == PH_BITS && accept, "event outside slot")
   `DMXSR_ASSERT_NOW(a_pos_range, phase_ff == PH_BITS, bit_pos_ff <= LAST_BIT, "bit position overrun")

endmodule

`default_nettype wire

[rtl/core/dmxsr_queue.sv]
// ----------------------------------------------------------------------------
// dmxsr_queue
// short event queue between framing front and slot assembler
// ----------------------------------------------------------------------------
`default_nettype none
`include "dmx512_slot_receiver_unit_defines.svh"

module dmxsr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  dmxsr_pkg::event_type push_data,
   input  logic                 pop,
   output dmxsr_pkg::event_type head,
   output logic                 empty,
   output logic                 full
);
   import dmxsr_pkg::*;

   event_type              mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign empty   = count_ff == '0;
   assign full    = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + {{(QUEUE_PTR_W-1){1'b0}}, 1'b1} : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + {{(QUEUE_PTR_W-1){1'b0}}, 1'b1} : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + {{(QUEUE_CNT_W-1){1'b0}}, 1'b1};
      end else if (do_pop && !do_push) begin
         count_in = count_ff - {{(QUEUE_CNT_W-1){1'b0}}, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   `DMXSR_ASSERT_NOW(a_no_overflow, full, !push, "push into full queue")

endmodule

`default_nettype wire

[rtl/core/dmxsr_back.sv]
// ----------------------------------------------------------------------------
// dmxsr_back
// slot assembler: builds the byte, checks framing, counts faults
// ----------------------------------------------------------------------------
`default_nettype none
`include "dmx512_slot_receiver_unit_defines.svh"

module dmxsr_back (
   input  logic                               clock,
   input  logic                               reset,
   input  dmxsr_pkg::event_type               head,
   input  logic                               empty,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [dmxsr_pkg::SLOT_NUM_W-1:0]   rsp_slot_number,
   output logic [dmxsr_pkg::BYTE_W-1:0]       rsp_slot_value,
   output logic                               rsp_slot_fault,
   output logic [dmxsr_pkg::FAULT_W-1:0]      rsp_fault_total,
   output logic                               rsp_frame_end
);
   import dmxsr_pkg::*;

   logic                  start_fault_ff, start_fault_in;
   logic [BYTE_W-1:0]     data_ff, data_in;
   logic [1:0]            stop_ones_ff, stop_ones_in;
   logic [FAULT_W-1:0]    fault_cnt_ff, fault_cnt_in;

   logic                  valid_ff, valid_in;
   logic [SLOT_NUM_W-1:0] num_ff, num_in;
   logic [BYTE_W-1:0]     value_ff, value_in;
   logic                  fault_ff, fault_in;
   logic [FAULT_W-1:0]    total_ff, total_in;
   logic                  end_ff, end_in;

   logic                  out_free;
   logic                  final_bit;
   logic [2:0]            data_idx;
   logic [1:0]            stop_sum;
   logic                  slot_bad;

   assign out_free  = !valid_ff || !rsp_stall;
   assign final_bit = head.bit_pos == LAST_BIT;
   assign pop       = !empty && (!final_bit || out_free);
   assign data_idx  = 3'(head.bit_pos - {{(BIT_POS_W-1){1'b0}}, 1'b1});
   assign stop_sum  = stop_ones_ff + {1'b0, head.level};
   assign slot_bad  = start_fault_ff || (stop_sum != 2'd2);

   always_comb begin
      start_fault_in = start_fault_ff;
      data_in        = data_ff;
      stop_ones_in   = stop_ones_ff;
      fault_cnt_in   = fault_cnt_ff;
      valid_in       = valid_ff && rsp_stall;
      num_in         = num_ff;
      value_in       = value_ff;
      fault_in       = fault_ff;
      total_in       = total_ff;
      end_in         = end_ff;
      if (pop) begin
         if (head.bit_pos == START_BIT) begin
            start_fault_in = head.level;
            data_in        = '0;
            stop_ones_in   = '0;
            if (head.slot_num == '0) begin
               fault_cnt_in = '0;
            end
         end else if (head.bit_pos <= LAST_DATA_BIT) begin
            data_in[data_idx] = data_ff[data_idx] | head.level;
         end else begin
            stop_ones_in = stop_sum;
         end
         if (final_bit) begin
            if (slot_bad && !(&fault_cnt_ff)) begin
               fault_cnt_in = fault_cnt_ff + {{(FAULT_W-1){1'b0}}, 1'b1};
            end
            valid_in = 1'b1;
            num_in   = head.slot_num;
            value_in = data_ff;
            fault_in = slot_bad;
            total_in = (slot_bad && !(&fault_cnt_ff))
                       ? fault_cnt_ff + {{(FAULT_W-1){1'b0}}, 1'b1} : fault_cnt_ff;
            end_in   = head.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_fault_ff <= 1'b0;
         data_ff        <= '0;
         stop_ones_ff   <= '0;
         fault_cnt_ff   <= '0;
         valid_ff       <= 1'b0;
      end else begin
         start_fault_ff <= start_fault_in;
         data_ff        <= data_in;
         stop_ones_ff   <= stop_ones_in;
         fault_cnt_ff   <= fault_cnt_in;
         valid_ff       <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      value_ff <= value_in;
      fault_ff <= fault_in;
      total_ff <= total_in;
      end_ff   <= end_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_slot_number = num_ff;
   assign rsp_slot_value  = value_ff;
   assign rsp_slot_fault  = fault_ff;
   assign rsp_fault_total = total_ff;
   assign rsp_frame_end   = end_ff;

   `DMXSR_ASSERT_NOW(a_final_needs_room, pop && final_bit, out_free, "result overwritten")
   `DMXSR_ASSERT_NOW(a_last_slot_num, valid_ff && end_ff,
      num_ff == SLOT_NUM_W'(FRAME_SLOTS - 1), "frame end on wrong slot")
   `DMXSR_ASSERT_NOW(a_total_bounds, valid_ff && fault_ff, total_ff != '0, "fault not counted")

endmodule

`default_nettype wire

[rtl/core/dmx512_slot_receiver_unit.sv]
// ----------------------------------------------------------------------------
// dmx512_slot_receiver_unit
// dmx512 frame receiver: one line sample per tick in, one record per slot out
// ----------------------------------------------------------------------------
//  channel   prefix  direction  contents
//  samples   req_    in         line_level, one per tick
//  slots     rsp_    out        slot_number, slot_value, slot_fault, fault_total,
//                               frame_end
//  control   csr_    in         idle_min_ticks, break_min_ticks, bit_ticks
//
//  one sample is taken every cycle while the event queue has room
//  a slot record is registered once the event of its second stop bit leaves the event queue
//  and the output register is free
//  a stalled slot output fills the four-entry event queue, then req_stall rises
//  reset is synchronous; limits return to 1000, 1000 and 4 ticks, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module dmx512_slot_receiver_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_line_level,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [dmxsr_pkg::SLOT_NUM_W-1:0]   rsp_slot_number,
   output logic [dmxsr_pkg::BYTE_W-1:0]       rsp_slot_value,
   output logic                               rsp_slot_fault,
   output logic [dmxsr_pkg::FAULT_W-1:0]      rsp_fault_total,
   output logic                               rsp_frame_end,
   input  logic                               csr_wr_en,
   input  logic [dmxsr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dmxsr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dmxsr_pkg::*;

   event_type ev_in;
   event_type ev_head;
   logic      ev_push;
   logic      ev_pop;
   logic      q_empty;
   logic      q_full;

   dmxsr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_line_level (req_line_level),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .queue_full     (q_full),
      .ev_push        (ev_push),
      .ev_out         (ev_in)
   );

   dmxsr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_push),
      .push_data (ev_in),
      .pop       (ev_pop),
      .head      (ev_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   dmxsr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (ev_head),
      .empty           (q_empty),
      .pop             (ev_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_slot_number (rsp_slot_number),
      .rsp_slot_value  (rsp_slot_value),
      .rsp_slot_fault  (rsp_slot_fault),
      .rsp_fault_total (rsp_fault_total),
      .rsp_frame_end   (rsp_frame_end)
   );

endmodule

`default_nettype wire

[tb/dmx512_slot_receiver_unit_test.sv]
// ----------------------------------------------------------------------------
// dmx512_slot_receiver_unit_test
// Drives line samples into the slot receiver one transfer at a time and keeps
// a cycle-free model of the framing state (idle wait, break, slot wait, bit
// sampling) in step with every accepted sample. Each slot record that leaves
// the block is compared field by field with the oldest predicted record.
// Directed tests cover limit boundaries, framing faults, bit period extremes
// and limit extremes; random rounds then mix well-formed slots with noise
// under changing limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dmx512_slot_receiver_unit_test;

   import dmxsr_pkg::*;

   localparam int RUN_LIMIT_NS  = 30_000_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 20;
   localparam int RANDOM_ITEMS  = 220;
   localparam int RANDOM_SLOTS  = 3;
   localparam int BOUND_IDLE    = 12;
   localparam int BOUND_BREAK   = 10;
   localparam int EXTREME_RUN   = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [TIMER_W-1:0]   TIMER_MAX  = '1;
   localparam logic [FAULT_W-1:0]   FAULT_MAX  = '1;

   typedef enum logic [1:0] {
      LINE_IDLE,
      LINE_BREAK,
      LINE_WAIT_SLOT,
      LINE_BITS
   } line_phase_type;

   typedef struct packed {
      logic [SLOT_NUM_W-1:0] number;
      logic [BYTE_W-1:0]     value;
      logic                  fault;
      logic [FAULT_W-1:0]    total;
      logic                  frame_end;
   } slot_record_type;

   logic                  clock;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic                  req_line_level = 1'b1;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic [SLOT_NUM_W-1:0] rsp_slot_number;
   logic [BYTE_W-1:0]     rsp_slot_value;
   logic                  rsp_slot_fault;
   logic [FAULT_W-1:0]    rsp_fault_total;
   logic                  rsp_frame_end;
   logic                  csr_wr_en      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index      = '0;
   logic [CSR_DATA_W-1:0] csr_wdata      = '0;

   // framing tracker state
   logic [TIMER_W-1:0]     cfg_idle_min   = IDLE_MIN_RST;
   logic [TIMER_W-1:0]     cfg_break_min  = BREAK_MIN_RST;
   logic [BIT_TICKS_W-1:0] cfg_bit_ticks  = BIT_TICKS_RST;
   line_phase_type         rx_phase       = LINE_IDLE;
   logic [TIMER_W-1:0]     rx_elapsed     = '0;
   logic [BIT_POS_W-1:0]   rx_bit_pos     = '0;
   logic [BYTE_W-1:0]      rx_data        = '0;
   logic                   rx_start_bad   = 1'b0;
   logic [1:0]             rx_stop_ones   = '0;
   logic [SLOT_NUM_W-1:0]  rx_slot_idx    = '0;
   logic [FAULT_W-1:0]     rx_fault_count = '0;

   slot_record_type pending_slots[$];
   int              predicted_slots = 0;
   int              sent_items      = 0;
   int              mismatch_count  = 0;
   int              burst_left      = 0;
   int              stall_run       = 0;

   dmx512_slot_receiver_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_line_level  (req_line_level),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_slot_number (rsp_slot_number),
      .rsp_slot_value  (rsp_slot_value),
      .rsp_slot_fault  (rsp_slot_fault),
      .rsp_fault_total (rsp_fault_total),
      .rsp_frame_end   (rsp_frame_end),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("Mismatches found");
      $finish;
   end

   // receiver stall pattern: runs of stall or no stall, mostly quiet
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else if (stall_run == 0) begin
         stall_run <= $urandom_range(1, 40);
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end else begin
         stall_run <= stall_run - 1;
      end
   end

   always @(posedge clock) begin
      slot_record_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_slots.size() == 0) begin
            $error("unexpected slot transfer: slot_number %0d", rsp_slot_number);
            mismatch_count++;
         end else begin
            want = pending_slots.pop_front();
            if (rsp_slot_number !== want.number) begin
               $error("slot_number: expected %0d, actual %0d", want.number, rsp_slot_number);
               mismatch_count++;
            end
            if (rsp_slot_value !== want.value) begin
               $error("slot_value: expected %0d, actual %0d", want.value, rsp_slot_value);
               mismatch_count++;
            end
            if (rsp_slot_fault !== want.fault) begin
               $error("slot_fault: expected %0d, actual %0d", want.fault, rsp_slot_fault);
               mismatch_count++;
            end
            if (rsp_fault_total !== want.total) begin
               $error("fault_total: expected %0d, actual %0d", want.total, rsp_fault_total);
               mismatch_count++;
            end
            if (rsp_frame_end !== want.frame_end) begin
               $error("frame_end: expected %0d, actual %0d", want.frame_end, rsp_frame_end);
               mismatch_count++;
            end
         end
      end
   end

   function automatic logic [BIT_TICKS_W-1:0] effective_period();
      return (cfg_bit_ticks < BIT_TICKS_MIN) ? BIT_TICKS_MIN : cfg_bit_ticks;
   endfunction

   // advances the framing state by one line sample, queues a slot record if one completes
   task automatic track_line_sample(input logic level);
      logic [BIT_TICKS_W-1:0] period;
      logic [BIT_TICKS_W-1:0] mid;
      logic                   bad;
      logic                   last;
      slot_record_type        rec;
      period = effective_period();
      mid    = period >> 1;
      case (rx_phase)
         LINE_IDLE: begin
            if (level) begin
               if (rx_elapsed != TIMER_MAX) rx_elapsed++;
            end else if (rx_elapsed > cfg_idle_min) begin
               rx_phase   = LINE_BREAK;
               rx_elapsed = TIMER_W'(1);
            end else begin
               rx_elapsed = '0;
            end
         end
         LINE_BREAK: begin
            if (!level) begin
               if (rx_elapsed != TIMER_MAX) rx_elapsed++;
            end else if (rx_elapsed > cfg_break_min) begin
               rx_phase       = LINE_WAIT_SLOT;
               rx_elapsed     = '0;
               rx_slot_idx    = '0;
               rx_fault_count = '0;
            end else begin
               rx_phase   = LINE_IDLE;
               rx_elapsed = TIMER_W'(1);
            end
         end
         LINE_WAIT_SLOT: begin
            if (!level) begin
               rx_phase     = LINE_BITS;
               rx_elapsed   = '0;
               rx_bit_pos   = START_BIT;
               rx_data      = '0;
               rx_start_bad = 1'b0;
               rx_stop_ones = '0;
            end
         end
         default: begin
            rx_elapsed++;
            if (rx_elapsed >= period) begin
               rx_elapsed = '0;
               rx_bit_pos++;
            end
            if (rx_elapsed == mid) begin
               if (rx_bit_pos == START_BIT) rx_start_bad = level;
               else if (rx_bit_pos <= LAST_DATA_BIT) rx_data[rx_bit_pos - 4'd1] = level;
               else rx_stop_ones = rx_stop_ones + {1'b0, level};
               if (rx_bit_pos >= LAST_BIT) begin
                  bad  = rx_start_bad || (rx_stop_ones != 2'd2);
                  last = (rx_slot_idx + 1) >= FRAME_SLOTS;
                  if (bad && rx_fault_count != FAULT_MAX) rx_fault_count++;
                  rec.number    = rx_slot_idx;
                  rec.value     = rx_data;
                  rec.fault     = bad;
                  rec.total     = rx_fault_count;
                  rec.frame_end = last;
                  pending_slots.push_back(rec);
                  predicted_slots++;
                  rx_slot_idx++;
                  rx_bit_pos = '0;
                  rx_elapsed = '0;
                  rx_phase   = last ? LINE_IDLE : LINE_WAIT_SLOT;
               end
            end
         end
      endcase
   endtask

   task automatic send_sample(input logic level);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(200, 600)
                                                  : $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_line_level <= level;
      do @(posedge clock); while (req_stall);
      track_line_sample(level);
      sent_items++;
   endtask

   task automatic send_level(input logic level, input int count);
      repeat (count) send_sample(level);
   endtask

   task automatic send_noise(input int count);
      repeat (count) send_sample($urandom_range(0, 1));
   endtask

   // start bit, 8 data bits lsb first, two stop bits; the first sample is always low
   task automatic send_slot(input logic [LAST_BIT:0] bits);
      int period;
      period = effective_period();
      for (int b = 0; b <= LAST_BIT; b++)
         for (int t = 0; t < period; t++)
            send_sample((b == 0 && t == 0) ? 1'b0 : bits[b]);
   endtask

   function automatic logic [LAST_BIT:0] random_slot_bits(input int fault_pct);
      logic [31:0] draw;
      draw = $urandom;
      if ($urandom_range(0, 99) < fault_pct) return draw[LAST_BIT:0];
      return {2'b11, draw[BYTE_W-1:0], 1'b0};
   endfunction

   // waits for the line to settle and the block to drain before the write
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      while (rx_phase == LINE_BITS || rx_phase == LINE_BREAK) send_sample(1'b1);
      req_valid <= 1'b0;
      while (pending_slots.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (index)
         CSR_IDLE_MIN:  cfg_idle_min  = data[TIMER_W-1:0];
         CSR_BREAK_MIN: cfg_break_min = data[TIMER_W-1:0];
         CSR_BIT_TICKS: cfg_bit_ticks = data[BIT_TICKS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic test_limit_boundaries();
      write_register(CSR_IDLE_MIN, CSR_DATA_W'(BOUND_IDLE));
      write_register(CSR_BREAK_MIN, CSR_DATA_W'(BOUND_BREAK));
      // idle exactly at the limit is not enough
      send_level(1'b1, BOUND_IDLE);
      send_level(1'b0, 1);
      // break exactly at the limit falls back to idle wait
      send_level(1'b1, BOUND_IDLE + 1);
      send_level(1'b0, BOUND_BREAK);
      send_level(1'b1, 1);
      send_level(1'b1, BOUND_IDLE);
      send_level(1'b0, BOUND_BREAK + 1);
      send_level(1'b1, 1);
      send_slot({2'b11, 8'h00, 1'b0});
      send_slot({2'b11, 8'hA5, 1'b0});
   endtask

   task automatic test_framing_faults();
      write_register(CSR_BIT_TICKS, 20'd3);
      send_slot({2'b11, 8'h3C, 1'b1});
      send_slot({2'b10, 8'h81, 1'b0});
      send_slot({2'b01, 8'h18, 1'b0});
      // low line after a bad stop bit starts the next slot at once
      send_slot({2'b01, 8'h42, 1'b0});
      send_level(1'b1, LAST_BIT * effective_period() + effective_period() + 1);
      send_slot({2'b11, 8'h99, 1'b0});
   endtask

   task automatic test_bit_periods();
      write_register(CSR_BIT_TICKS, {12'($urandom), 8'd0});
      send_slot({2'b11, 8'hFF, 1'b0});
      write_register(CSR_BIT_TICKS, 20'd1);
      send_slot({2'b11, 8'h96, 1'b0});
      write_register(CSR_BIT_TICKS, 20'd3);
      send_slot({2'b11, 8'h5A, 1'b0});
      send_slot({2'b11, 8'h0F, 1'b1});
      write_register(CSR_BIT_TICKS, 20'd9);
      send_slot({2'b11, 8'hC3, 1'b0});
      write_register(CSR_UNUSED, 20'hFFFFF);
      write_register(CSR_BIT_TICKS, 20'd2);
      send_slot({2'b11, 8'h24, 1'b0});
   endtask

   task automatic test_limit_extremes();
      write_register(CSR_IDLE_MIN, TIMER_MAX);
      write_register(CSR_BREAK_MIN, TIMER_MAX);
      send_level(1'b1, EXTREME_RUN);
      send_level(1'b0, 1);
      write_register(CSR_IDLE_MIN, 20'd0);
      send_level(1'b1, 1);
      send_level(1'b0, EXTREME_RUN);
      send_level(1'b1, 1);
      write_register(CSR_BREAK_MIN, 20'd0);
      send_level(1'b0, 1);
      send_level(1'b1, 1);
      send_slot({2'b11, 8'h00, 1'b0});
      send_slot({2'b11, 8'h7E, 1'b0});
      write_register(CSR_IDLE_MIN, 20'd1);
      write_register(CSR_BREAK_MIN, 20'd1);
   endtask

   task automatic run_random_round();
      int stop_at;
      int pick;
      pick = $urandom_range(0, 15);
      if (pick < 2) write_register(CSR_BIT_TICKS, CSR_DATA_W'(pick));
      else if (pick == 2) write_register(CSR_BIT_TICKS, CSR_DATA_W'($urandom_range(7, 9)));
      else write_register(CSR_BIT_TICKS, CSR_DATA_W'($urandom_range(2, 6)));
      write_register(CSR_IDLE_MIN, CSR_DATA_W'($urandom_range(1, 12)));
      write_register(CSR_BREAK_MIN, CSR_DATA_W'($urandom_range(1, 12)));
      stop_at = sent_items + $urandom_range(40, 100);
      while (sent_items < stop_at) begin
         case (rx_phase)
            LINE_IDLE: begin
               if ($urandom_range(0, 4) != 0) begin
                  send_level(1'b1, cfg_idle_min + $urandom_range(1, 6));
                  if ($urandom_range(0, 5) == 0) send_level(1'b0, $urandom_range(1, cfg_break_min));
                  else send_level(1'b0, cfg_break_min + $urandom_range(1, 6));
                  send_level(1'b1, $urandom_range(1, 4));
               end else begin
                  send_noise($urandom_range(1, 20));
               end
            end
            LINE_WAIT_SLOT: begin
               if ($urandom_range(0, 9) < 8) begin
                  send_slot(random_slot_bits(15));
                  send_level(1'b1, $urandom_range(0, 3));
               end else begin
                  send_noise($urandom_range(1, 15));
               end
            end
            default: send_noise($urandom_range(1, 8));
         endcase
      end
   endtask

   task automatic test_random_traffic();
      int first_item;
      int first_slot;
      first_item = sent_items;
      first_slot = predicted_slots;
      while (sent_items - first_item < RANDOM_ITEMS ||
             predicted_slots - first_slot < RANDOM_SLOTS)
         run_random_round();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_limit_boundaries();
      test_framing_faults();
      test_bit_periods();
      test_limit_extremes();
      test_random_traffic();
      req_valid <= 1'b0;
      while (pending_slots.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
